// ----- hdl/ecal_pkg.sv -----
// ecal_pkg: constants and helpers for the epoch seconds to calendar converter.
// No dependencies; imported by the response channel interface and the top level.

package ecal_pkg;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DOM_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int WDAY_W  = 3;
   localparam int DOY_W   = 9;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [10:0] EPOCH_YEAR    = 11'd1970;
   localparam logic [8:0]  DAYS_YEAR     = 9'd365;
   localparam logic [8:0]  DAYS_LEAP     = 9'd366;

   localparam logic [3:0]  MONTH_LAST    = 4'd11;   // December, zero based
   localparam logic [2:0]  EPOCH_WDAY    = 3'd4;    // 1970-01-01 was a Thursday
   localparam logic [2:0]  DAYS_WEEK     = 3'd7;

   // Month length, zero-based month index
   function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
      logic [4:0] len;
      case (idx)
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- hdl/ecal_if.sv -----
// ecal_if: valid/ready channel interfaces for request and response.
// Depends on ecal_pkg for the result field widths.

interface ecal_req_if #(parameter int SECONDS_BITS = 32);
   logic                    valid;
   logic                    ready;
   logic [SECONDS_BITS-1:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_rsp_if;
   import ecal_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [YEAR_W-1:0]    year;
   logic [MONTH_W-1:0]   month;
   logic [DOM_W-1:0]     day_of_month;
   logic [HOUR_W-1:0]    hour;
   logic [MIN_W-1:0]     minute;
   logic [SEC_W-1:0]     second;
   logic [WDAY_W-1:0]    weekday;
   logic [DOY_W-1:0]     day_of_year;

   modport source (output valid, output year, output month, output day_of_month,
                   output hour, output minute, output second, output weekday,
                   output day_of_year, input ready);
   modport sink   (input valid, input year, input month, input day_of_month,
                   input hour, input minute, input second, input weekday,
                   input day_of_year, output ready);
endinterface

// ----- hdl/epoch_seconds_to_calendar.sv -----
// Unix seconds to Gregorian date/time, one shared subtract/compare unit.
// Steps from the accepting edge: day division, hour and minute division, year walk,
// month walk, then rsp valid. The year walk dominates the conversion time.
// One request is converted at a time (ready only in idle); a new request is taken
// while a result waits. Reset (synchronous, active high) returns to idle, drops rsp valid.
// Depends on ecal_pkg and ecal_if.

module epoch_seconds_to_calendar #(
   parameter int SECONDS_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   ecal_req_if.sink            req_chan,
   ecal_rsp_if.source          rsp_chan
);
   import ecal_pkg::*;

   localparam int W         = SECONDS_BITS;
   localparam int DAYS_BITS = SECONDS_BITS - 16;
   localparam int CNT_BITS  = $clog2(DAYS_BITS);
   localparam int YEAR_BITS = (DAYS_BITS > 19) ? DAYS_BITS - 7 : 12;

   localparam logic [W-1:0] DAY_DIV_TOP  = W'(SECS_PER_DAY) << (DAYS_BITS - 1);
   localparam logic [W-1:0] HOUR_DIV_TOP = W'(SECS_PER_HOUR) << (HOUR_W - 1);
   localparam logic [W-1:0] MIN_DIV_TOP  = W'(SECS_PER_MIN) << (MIN_W - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DAYS   = 3'd1;
   localparam logic [2:0] ST_HOURS  = 3'd2;
   localparam logic [2:0] ST_MINS   = 3'd3;
   localparam logic [2:0] ST_YEARS  = 3'd4;
   localparam logic [2:0] ST_MONTHS = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [W-1:0]         work_ff, work_in;     // seconds remainder
   logic [DAYS_BITS-1:0] quot_ff, quot_in;     // days, then day within year/month
   logic [W-1:0]         div_ff, div_in;       // shifted divisor
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [2:0]           wmod_ff, wmod_in;     // days mod 7, built bit by bit
   logic [HOUR_W-1:0]    hour_ff, hour_in;
   logic [MIN_W-1:0]     min_ff, min_in;
   logic [YEAR_BITS-1:0] year_ff, year_in;
   logic [1:0]           m4_ff, m4_in;
   logic [6:0]           m100_ff, m100_in;
   logic [8:0]           m400_ff, m400_in;
   logic [DOY_W-1:0]     doy_ff, doy_in;
   logic [3:0]           midx_ff, midx_in;

   logic                 out_valid_ff, out_valid_in;
   logic [YEAR_W-1:0]    out_year_ff;
   logic [MONTH_W-1:0]   out_month_ff;
   logic [DOM_W-1:0]     out_dom_ff;
   logic [HOUR_W-1:0]    out_hour_ff;
   logic [MIN_W-1:0]     out_min_ff;
   logic [SEC_W-1:0]     out_sec_ff;
   logic [WDAY_W-1:0]    out_wday_ff;
   logic [DOY_W-1:0]     out_doy_ff;

   // shared subtract/compare unit
   logic [W-1:0] op_a, op_b;
   logic [W:0]   diff;
   logic         ge;
   logic         leap;
   logic [3:0]   wmod_dbl;
   logic [2:0]   wday_fin;
   logic         accept, finish, load;

   assign leap = (m4_ff == 2'd0) && ((m100_ff != 7'd0) || (m400_ff == 9'd0));

   always_comb begin
      case (state_ff)
         ST_YEARS: begin
            op_a = W'(quot_ff);
            op_b = W'(leap ? DAYS_LEAP : DAYS_YEAR);
         end
         ST_MONTHS: begin
            op_a = W'(quot_ff);
            op_b = W'(month_len(midx_ff, leap));
         end
         default: begin
            op_a = work_ff;
            op_b = div_ff;
         end
      endcase
   end

   assign diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge   = !diff[W];

   assign wmod_dbl = {wmod_ff, ge};
   assign wday_fin = (wmod_ff >= DAYS_WEEK - EPOCH_WDAY) ? wmod_ff - (DAYS_WEEK - EPOCH_WDAY)
                                                          : wmod_ff + EPOCH_WDAY;

   assign accept = req_chan.valid && req_chan.ready;
   assign finish = (state_ff == ST_MONTHS) && ((midx_ff == MONTH_LAST) || !ge);
   assign load   = finish && (!out_valid_ff || rsp_chan.ready);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      wmod_in  = wmod_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      year_in  = year_ff;
      m4_in    = m4_ff;
      m100_in  = m100_ff;
      m400_in  = m400_ff;
      doy_in   = doy_ff;
      midx_in  = midx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DAYS;
               work_in  = req_chan.epoch_seconds;
               quot_in  = '0;
               div_in   = DAY_DIV_TOP;
               cnt_in   = CNT_BITS'(DAYS_BITS - 1);
               wmod_in  = '0;
            end
         end
         ST_DAYS: begin
            if (ge) work_in = diff[W-1:0];
            quot_in = {quot_ff[DAYS_BITS-2:0], ge};
            wmod_in = (wmod_dbl >= 4'(DAYS_WEEK)) ? 3'(wmod_dbl - 4'(DAYS_WEEK))
                                                  : wmod_dbl[2:0];
            div_in  = div_ff >> 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_HOURS;
               div_in   = HOUR_DIV_TOP;
               cnt_in   = CNT_BITS'(HOUR_W - 1);
            end
         end
         ST_HOURS: begin
            if (ge) work_in = diff[W-1:0];
            hour_in = {hour_ff[HOUR_W-2:0], ge};
            div_in  = div_ff >> 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_MINS;
               div_in   = MIN_DIV_TOP;
               cnt_in   = CNT_BITS'(MIN_W - 1);
            end
         end
         ST_MINS: begin
            if (ge) work_in = diff[W-1:0];
            min_in = {min_ff[MIN_W-2:0], ge};
            div_in = div_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_YEARS;
               year_in  = YEAR_BITS'(EPOCH_YEAR);
               m4_in    = 2'd2;
               m100_in  = 7'd70;
               m400_in  = 9'd370;
            end
         end
         ST_YEARS: begin
            if (ge) begin
               quot_in = diff[DAYS_BITS-1:0];
               year_in = year_ff + 1'b1;
               m4_in   = m4_ff + 1'b1;
               m100_in = (m100_ff == 7'd99) ? 7'd0 : m100_ff + 1'b1;
               m400_in = (m400_ff == 9'd399) ? 9'd0 : m400_ff + 1'b1;
            end else begin
               state_in = ST_MONTHS;
               doy_in   = quot_ff[DOY_W-1:0];
               midx_in  = '0;
            end
         end
         ST_MONTHS: begin
            if (!finish) begin
               quot_in = diff[DAYS_BITS-1:0];
               midx_in = midx_ff + 1'b1;
            end else if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) out_valid_in = 1'b1;
      else if (rsp_chan.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      wmod_ff <= wmod_in;
      hour_ff <= hour_in;
      min_ff  <= min_in;
      year_ff <= year_in;
      m4_ff   <= m4_in;
      m100_ff <= m100_in;
      m400_ff <= m400_in;
      doy_ff  <= doy_in;
      midx_ff <= midx_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_year_ff  <= year_ff[YEAR_W-1:0];
         out_month_ff <= midx_ff + 1'b1;
         out_dom_ff   <= quot_ff[DOM_W-1:0] + 1'b1;
         out_hour_ff  <= hour_ff;
         out_min_ff   <= min_ff;
         out_sec_ff   <= work_ff[SEC_W-1:0];
         out_wday_ff  <= wday_fin;
         out_doy_ff   <= doy_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.year         = out_year_ff;
   assign rsp_chan.month        = out_month_ff;
   assign rsp_chan.day_of_month = out_dom_ff;
   assign rsp_chan.hour         = out_hour_ff;
   assign rsp_chan.minute       = out_min_ff;
   assign rsp_chan.second       = out_sec_ff;
   assign rsp_chan.weekday      = out_wday_ff;
   assign rsp_chan.day_of_year  = out_doy_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DAYS))
      else $error("transfer did not start the day division");

   a_leap_counters: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEARS) |-> ((m4_ff == m100_ff[1:0]) && (m4_ff == m400_ff[1:0])))
      else $error("leap cycle counters out of step");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTHS) |-> (midx_ff <= MONTH_LAST))
      else $error("month index past December");

   a_tod_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_HOURS) || (state_ff == ST_MINS)) |-> (work_ff < W'(SECS_PER_DAY)))
      else $error("time of day remainder not below one day");

   a_load_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |-> !load)
      else $error("result overwritten before transfer");

endmodule
